FILE: hw/rtl/skns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skns_pkg: shared types and constants for the sorted key nearest search
// Holds the key type and the power-up contents of the first table entries.
// ----------------------------------------------------------------------------
package skns_pkg;

    // Signed Q16.16 key, as held in the table and given with a query.
    typedef logic signed [31:0] key_t;

    // Entries whose contents are defined after reset.
    localparam int INIT_COUNT = 4;

    // Power-up keys for the first entries: -1.0, 0.0, 1.0 and 2.0.
    localparam key_t INIT_KEYS [0:INIT_COUNT-1] = '{
        32'shFFFF0000,
        32'sh00000000,
        32'sh00010000,
        32'sh00020000
    };

endpackage

FILE: hw/rtl/skns_key_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skns_key_store: key table with one write port and one registered read port
// Entries below INIT_COUNT read as their power-up keys until first written.
// ----------------------------------------------------------------------------
module skns_key_store
    import skns_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_key,
    input  logic [AW-1:0] rd_addr,
    output key_t          rd_key
);

    localparam int INIT_N = (DEPTH < INIT_COUNT) ? DEPTH : INIT_COUNT;

    key_t              mem [0:DEPTH-1];
    key_t              rd_data_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [INIT_N-1:0] init_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_key;
        end
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // Once an initialised entry has been written the memory holds its value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_written_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < INIT_N; i++)
            begin
                if (wr_en && (wr_addr == AW'(i)))
                begin
                    init_written_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rd_key = rd_data_reg;
        for (int i = 0; i < INIT_N; i++)
        begin
            if ((rd_addr_reg == AW'(i)) && !init_written_reg[i])
            begin
                rd_key = INIT_KEYS[i];
            end
        end
    end

endmodule

FILE: hw/rtl/sorted_key_nearest_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_nearest_search: nearest-key binary search over a sorted table
// Stores signed Q16.16 keys and answers queries with next and nearest index.
// ----------------------------------------------------------------------------
// A write item (cmd = 0) stores entry_key at entry_index in the same cycle it
// is accepted and raises no result; busy stays low, so writes may be issued
// back to back. Writes to an index at or beyond TABLE_DEPTH are dropped. A
// query item (cmd = 1) raises busy and runs a binary search over the first
// entries_in_use keys (zero is taken as one, values above TABLE_DEPTH are
// capped). Each halving step first reads the middle key from the table's
// single read port (S_MID) and then compares it in the shared 33-bit
// subtractor (S_CMP); the final neighbour check reads the next and
// previous keys in turn through the same port and subtractor. An exact
// match ends the search early, and a next index of zero skips the
// neighbour check. The result appears in the same cycle that busy falls,
// for exactly one cycle with done high; the receiver cannot stall it, so
// it must be captured in that cycle. Entries zero to three hold -1.0, 0.0,
// 1.0 and 2.0 after reset; all other entries must be written before a
// query reaches them. entries_in_use may only be changed while busy
// is low.
// ----------------------------------------------------------------------------
module sorted_key_nearest_search
    import skns_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       start,
    output logic       busy,
    input  logic       cmd,
    input  logic [5:0] entry_index,
    input  key_t       entry_key,
    input  key_t       query_key,
    output logic       done,
    output logic [5:0] next_index,
    output logic [5:0] closest_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Wide enough for both the register value and the depth itself.
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MID  = 6'b000010,
        S_CMP  = 6'b000100,
        S_RDN  = 6'b001000,
        S_RDP  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]        entries_in_use_reg;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic [AW-1:0]     next_reg, next_next;
    key_t              query_reg, query_next;
    logic signed [32:0] diff_reg, diff_next;
    logic              done_reg, done_next;
    logic [5:0]        next_out_reg, next_out_next;
    logic [5:0]        near_out_reg, near_out_next;

    // Table port
    logic          tbl_wr_en;
    logic [AW-1:0] rd_addr;
    key_t          rd_key;

    // Shared subtractor: sub_res = sub_a - sub_b, exact at 33 bits.
    key_t               sub_a, sub_b;
    logic signed [32:0] sub_res;
    logic               key_gt, key_lt;

    logic [CW-1:0] count_raw;
    logic [CW-1:0] count_sat;
    logic [AW:0]   mid_sum;
    logic [AW-1:0] mid_val;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= 7'd4;
        end
        else if (cfg_wr_en)
        begin
            entries_in_use_reg <= cfg_wr_data;
        end
    end

    // Clamp the entries in use to the range one to TABLE_DEPTH.
    always_comb
    begin
        count_raw = CW'(entries_in_use_reg);
        count_sat = count_raw;
        if (count_raw == '0)
        begin
            count_sat = CW'(1);
        end
        else if (count_raw > CW'(TABLE_DEPTH))
        begin
            count_sat = CW'(TABLE_DEPTH);
        end
    end

    // ------------------------------------------------------------------
    // Key table
    // ------------------------------------------------------------------
    assign tbl_wr_en = start && !busy && !cmd
                       && ({26'd0, entry_index} < 32'(TABLE_DEPTH));

    skns_key_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_key_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_key  (entry_key),
        .rd_addr (rd_addr),
        .rd_key  (rd_key)
    );

    // ------------------------------------------------------------------
    // Shared compare unit
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_FIN)
        begin
            sub_a = query_reg;
            sub_b = rd_key;
        end
        else
        begin
            sub_a = rd_key;
            sub_b = query_reg;
        end
    end

    assign sub_res = {sub_a[31], sub_a} - {sub_b[31], sub_b};
    assign key_lt  = sub_res[32];
    assign key_gt  = !sub_res[32] && (sub_res != '0);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val = mid_sum[AW:1];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        next_next     = next_reg;
        query_next    = query_reg;
        diff_next     = diff_reg;
        done_next     = 1'b0;
        next_out_next = next_out_reg;
        near_out_next = near_out_reg;
        rd_addr       = mid_val;

        case (state_reg)
            S_IDLE:
            begin
                if (start && cmd)
                begin
                    lo_next    = '0;
                    hi_next    = AW'(count_sat - CW'(1));
                    query_next = query_key;
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                // Range has closed: the lower bound is the answer.
                if (lo_reg == hi_reg)
                begin
                    next_next  = lo_reg;
                    state_next = S_RDN;
                end
                else
                begin
                    rd_addr    = mid_val;
                    mid_next   = mid_val;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (mid_reg == lo_reg)
                begin
                    next_next  = key_lt ? hi_reg : lo_reg;
                    state_next = S_RDN;
                end
                else if (key_gt)
                begin
                    hi_next    = mid_reg;
                    state_next = S_MID;
                end
                else if (key_lt)
                begin
                    lo_next    = mid_reg;
                    state_next = S_MID;
                end
                else
                begin
                    next_next  = mid_reg;
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                if (next_reg == '0)
                begin
                    done_next     = 1'b1;
                    next_out_next = '0;
                    near_out_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    rd_addr    = next_reg;
                    state_next = S_RDP;
                end
            end
            S_RDP:
            begin
                // Distance to the next key, then fetch the previous one.
                diff_next  = sub_res;
                rd_addr    = next_reg - AW'(1);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next     = 1'b1;
                next_out_next = 6'(next_reg);
                if (sub_res < diff_reg)
                begin
                    near_out_next = 6'(next_reg - AW'(1));
                end
                else
                begin
                    near_out_next = 6'(next_reg);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        next_reg     <= next_next;
        query_reg    <= query_next;
        diff_reg     <= diff_next;
        next_out_reg <= next_out_next;
        near_out_reg <= near_out_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign next_index    = next_out_reg;
    assign closest_index = near_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result raised without a query in progress");

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd) |=> busy)
        else $error("accepted query did not start the search");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MID) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_nearest_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((closest_index == next_index)
                  || (closest_index == next_index - 6'd1)))
        else $error("nearest index not next index or its predecessor");

endmodule
